// ===== hw/rtl/ascii_command_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder assertion macros
// Shared concurrent assertion forms used by the frame decoder.
// ----------------------------------------------------------------------------
`ifndef ASCII_COMMAND_FRAME_DECODER_MACROS_SVH
`define ASCII_COMMAND_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ACFD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("acfd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ACFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("acfd: next-cycle check failed");

`endif

// ===== hw/rtl/acfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder package
// Shared characters, command codes, queue entry type and digit helper.
// ----------------------------------------------------------------------------
package acfd_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h3C;
    localparam logic [7:0] CH_CLOSE = 8'h3E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam int CODE_W = 16;

    localparam logic [CODE_W-1:0] SCALE_10   = 16'd10;
    localparam logic [CODE_W-1:0] SCALE_100  = 16'd100;
    localparam logic [CODE_W-1:0] SCALE_1000 = 16'd1000;

    localparam logic [CODE_W-1:0] CMD_MAIN_OFF = 16'd1;
    localparam logic [CODE_W-1:0] CMD_MAIN_ON  = 16'd2;
    localparam logic [CODE_W-1:0] CMD_STATUS   = 16'd4;

    localparam int CMD_DIGITS = 3;
    localparam int VAL_DIGITS = 4;
    // First slot of each digit field in the frame.
    localparam int CMD_FIRST_SLOT = 1;
    localparam int VAL_FIRST_SLOT = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte on its way from the front end to the decoder.
    // For a closing byte the digit bytes are slot contents as they stand after it.
    typedef struct packed {
        logic                             close;
        logic [CMD_DIGITS-1:0][7:0]       cmd_bytes;
        logic [VAL_DIGITS-1:0][7:0]       val_bytes;
    } frame_entry_t;

    // Slot byte minus ASCII zero, wrapped to the 16-bit code width.
    function automatic logic [CODE_W-1:0] digit_value(input logic [7:0] b);
        digit_value = {8'h00, b} - {8'h00, CH_ZERO};
    endfunction

endpackage

// ===== hw/rtl/ascii_command_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder
// Frames received bytes between '<' and '>' and decodes command and value.
// ----------------------------------------------------------------------------
// Every received byte produces exactly one result transaction carrying the
// main and status pin levels after that byte, a frame_done flag, and, when
// the byte was '>', the decoded 3-digit command (slots 1 to 3) and 4-digit
// value (slots 5 to 8), each digit taken as byte minus '0' and summed modulo
// 2^16. Command 1 clears the main pin, command 2 sets it, command 4 with a
// nonzero value clears the status pin and sets the main pin, and command 4
// with a zero value sets the status pin. Both pins come out of reset high.
// The block accepts one byte per clock while the queue has room. The accepting
// edge updates the slot store and writes the classified byte into a two-entry
// queue; the decoder loads the result register from the queue whenever that
// register is empty or being taken, so each result passes through a queue
// entry and then the result register. The queue separates the two sides, so
// up to two more bytes are accepted while a finished result waits to be taken;
// sustained throughput is one transaction per cycle while results are taken.
// ----------------------------------------------------------------------------
`include "ascii_command_frame_decoder_macros.svh"

module ascii_command_frame_decoder #(
    parameter int FRAME_SLOTS = 9
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_main_pin,
    output logic                        m_status_pin,
    output logic                        m_frame_done,
    output logic [acfd_pkg::CODE_W-1:0] m_command_code,
    output logic [acfd_pkg::CODE_W-1:0] m_data_value
);

    // Classified bytes travel from the front end through the queue.
    logic                   push_valid, push_ready;
    acfd_pkg::frame_entry_t push_entry;
    logic                   pop_valid, pop_ready;
    acfd_pkg::frame_entry_t pop_entry;

    // The front end owns the frame state and the slot store.
    acfd_front #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry)
    );

    acfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_entry(push_entry),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry)
    );

    // The back end owns the pin levels and the result register.
    acfd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_main_pin    (m_main_pin),
        .m_status_pin  (m_status_pin),
        .m_frame_done  (m_frame_done),
        .m_command_code(m_command_code),
        .m_data_value  (m_data_value)
    );

    // Results without a closed frame carry zero codes.
    `ACFD_ASSERT_IMPL(a_idle_codes_zero, aclk, aresetn,
        m_valid && !m_frame_done, (m_command_code == '0) && (m_data_value == '0))

    // A decoded main-off command leaves the main pin low.
    `ACFD_ASSERT_IMPL(a_cmd_main_off, aclk, aresetn,
        m_valid && m_frame_done && (m_command_code == acfd_pkg::CMD_MAIN_OFF),
        !m_main_pin)

    // A status command with a nonzero value clears status and raises main.
    `ACFD_ASSERT_IMPL(a_cmd_status_set, aclk, aresetn,
        m_valid && m_frame_done && (m_command_code == acfd_pkg::CMD_STATUS)
            && (m_data_value != '0),
        !m_status_pin && m_main_pin)

    // The queue hands an entry to the decoder whenever the result slot frees.
    `ACFD_ASSERT_NEXT(a_queue_drains, aclk, aresetn, pop_valid && !m_valid, m_valid)

endmodule

// ===== hw/rtl/acfd_front.sv =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder front end
// Accepts bytes, tracks the open frame and its slot store, and forwards one
// classified entry per byte to the queue.
// ----------------------------------------------------------------------------
module acfd_front #(
    parameter int FRAME_SLOTS = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    output logic                  push_valid,
    input  logic                  push_ready,
    output acfd_pkg::frame_entry_t push_entry
);

    localparam int IDX_W = $clog2(FRAME_SLOTS);

    logic             frame_open_reg, frame_open_next;
    logic [IDX_W-1:0] write_index_reg, write_index_next;
    logic [7:0]       frame_store_reg [FRAME_SLOTS];

    logic             accept;
    logic             is_open, is_close;
    logic             store_en;
    logic [IDX_W-1:0] store_idx;
    logic [IDX_W-1:0] step_idx;

    assign accept     = s_valid && push_ready;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    assign is_open  = (s_rx_byte == acfd_pkg::CH_OPEN);
    assign is_close = (s_rx_byte == acfd_pkg::CH_CLOSE);

    // An opening byte restarts the frame at slot zero and is stored there.
    assign store_idx = is_open ? '0 : write_index_reg;
    assign store_en  = is_open || is_close || frame_open_reg;
    assign step_idx  = (store_idx == IDX_W'(FRAME_SLOTS - 1)) ? '0 : store_idx + 1'b1;

    always_comb begin
        frame_open_next  = frame_open_reg;
        write_index_next = write_index_reg;
        if (is_open) begin
            frame_open_next  = 1'b1;
            write_index_next = step_idx;
        end else if (is_close) begin
            frame_open_next  = 1'b0;
            write_index_next = '0;
        end else if (frame_open_reg) begin
            write_index_next = step_idx;
        end
    end

    // The decode sees the store after the closing byte has been written.
    always_comb begin
        push_entry.close = is_close;
        for (int k = 0; k < acfd_pkg::CMD_DIGITS; k++) begin
            push_entry.cmd_bytes[k] =
                (write_index_reg == IDX_W'(acfd_pkg::CMD_FIRST_SLOT + k))
                ? acfd_pkg::CH_CLOSE : frame_store_reg[acfd_pkg::CMD_FIRST_SLOT + k];
        end
        for (int k = 0; k < acfd_pkg::VAL_DIGITS; k++) begin
            push_entry.val_bytes[k] =
                (write_index_reg == IDX_W'(acfd_pkg::VAL_FIRST_SLOT + k))
                ? acfd_pkg::CH_CLOSE : frame_store_reg[acfd_pkg::VAL_FIRST_SLOT + k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg  <= 1'b0;
            write_index_reg <= '0;
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                frame_store_reg[i] <= '0;
            end
        end else if (accept) begin
            frame_open_reg  <= frame_open_next;
            write_index_reg <= write_index_next;
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                if (store_en && (store_idx == IDX_W'(i))) begin
                    frame_store_reg[i] <= s_rx_byte;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/acfd_queue.sv =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder queue
// Two-entry queue that decouples the front end from the decoder.
// ----------------------------------------------------------------------------
module acfd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  acfd_pkg::frame_entry_t push_entry,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output acfd_pkg::frame_entry_t pop_entry
);

    acfd_pkg::frame_entry_t           entry_reg [acfd_pkg::QUEUE_DEPTH];
    logic [acfd_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [acfd_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [acfd_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign push_ready = (count_reg != acfd_pkg::QCNT_W'(acfd_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == acfd_pkg::QPTR_W'(acfd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == acfd_pkg::QPTR_W'(acfd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/acfd_back.sv =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder back end
// Decodes closed frames, drives the pin levels and holds the result register.
// ----------------------------------------------------------------------------
module acfd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  acfd_pkg::frame_entry_t        pop_entry,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_main_pin,
    output logic                          m_status_pin,
    output logic                          m_frame_done,
    output logic [acfd_pkg::CODE_W-1:0]   m_command_code,
    output logic [acfd_pkg::CODE_W-1:0]   m_data_value
);

    logic                        m_valid_reg;
    logic                        main_level_reg, main_level_next;
    logic                        status_level_reg, status_level_next;
    logic                        done_reg;
    logic [acfd_pkg::CODE_W-1:0] cmd_reg, cmd_next;
    logic [acfd_pkg::CODE_W-1:0] val_reg, val_next;
    logic                        do_pop;

    assign pop_ready = !m_valid_reg || m_ready;
    assign do_pop    = pop_valid && pop_ready;

    // Most significant digit sits in the lowest slot of each field.
    always_comb begin
        cmd_next = acfd_pkg::digit_value(pop_entry.cmd_bytes[2])
                 + acfd_pkg::digit_value(pop_entry.cmd_bytes[1]) * acfd_pkg::SCALE_10
                 + acfd_pkg::digit_value(pop_entry.cmd_bytes[0]) * acfd_pkg::SCALE_100;
        val_next = acfd_pkg::digit_value(pop_entry.val_bytes[3])
                 + acfd_pkg::digit_value(pop_entry.val_bytes[2]) * acfd_pkg::SCALE_10
                 + acfd_pkg::digit_value(pop_entry.val_bytes[1]) * acfd_pkg::SCALE_100
                 + acfd_pkg::digit_value(pop_entry.val_bytes[0]) * acfd_pkg::SCALE_1000;
        if (!pop_entry.close) begin
            cmd_next = '0;
            val_next = '0;
        end
    end

    always_comb begin
        main_level_next   = main_level_reg;
        status_level_next = status_level_reg;
        if (pop_entry.close) begin
            if (cmd_next == acfd_pkg::CMD_MAIN_OFF) begin
                main_level_next = 1'b0;
            end else if (cmd_next == acfd_pkg::CMD_MAIN_ON) begin
                main_level_next = 1'b1;
            end else if (cmd_next == acfd_pkg::CMD_STATUS) begin
                if (val_next != '0) begin
                    status_level_next = 1'b0;
                    main_level_next   = 1'b1;
                end else begin
                    status_level_next = 1'b1;
                end
            end
        end
    end

    // The pin levels change only when a result is loaded, so they double as
    // the held pin fields of the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            main_level_reg   <= 1'b1;
            status_level_reg <= 1'b1;
        end else if (do_pop) begin
            m_valid_reg      <= 1'b1;
            main_level_reg   <= main_level_next;
            status_level_reg <= status_level_next;
        end else if (m_ready) begin
            m_valid_reg      <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            done_reg <= pop_entry.close;
            cmd_reg  <= cmd_next;
            val_reg  <= val_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_main_pin     = main_level_reg;
    assign m_status_pin   = status_level_reg;
    assign m_frame_done   = done_reg;
    assign m_command_code = cmd_reg;
    assign m_data_value   = val_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// ASCII command frame decoder testbench
// Streams framed and unframed bytes into the decoder and checks every result
// transaction against a cycle-free model of the frame store and the pins.
// ----------------------------------------------------------------------------
// Each accepted byte is run through a local model of the decoder: the open
// flag, the write index, the nine-slot store and the two pin levels. The
// model's answer is queued, and a checker compares every result transaction,
// field by field, against the oldest queued answer. A short directed part
// covers bytes outside a frame, a close with no open frame and each command.
// Random frames follow, mostly well formed with random commands and values,
// the rest short, overlong, broken or pure noise. Both sides idle in random
// bursts, the receiver also holds off for a long stretch to stall the input,
// and the run closes with a stretch at full rate.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAME_SLOTS    = 9;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int FULL_RATE_ITEMS = 350;
    localparam int DRAIN_LIMIT    = 2000;

    // One result transaction as the decoder presents it.
    typedef struct packed {
        logic                        main_pin;
        logic                        status_pin;
        logic                        frame_done;
        logic [acfd_pkg::CODE_W-1:0] command_code;
        logic [acfd_pkg::CODE_W-1:0] data_value;
    } pin_result_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [7:0]                  s_rx_byte;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_main_pin;
    logic                        m_status_pin;
    logic                        m_frame_done;
    logic [acfd_pkg::CODE_W-1:0] m_command_code;
    logic [acfd_pkg::CODE_W-1:0] m_data_value;

    ascii_command_frame_decoder #(
        .FRAME_SLOTS(FRAME_SLOTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_main_pin    (m_main_pin),
        .m_status_pin  (m_status_pin),
        .m_frame_done  (m_frame_done),
        .m_command_code(m_command_code),
        .m_data_value  (m_data_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model state and run bookkeeping.
    // ------------------------------------------------------------------
    logic        frame_is_open;
    logic [3:0]  slot_index;
    logic [7:0]  slot_bytes [FRAME_SLOTS];
    logic        main_level;
    logic        status_level;

    pin_result_t expected_results [$];

    int error_count;
    int bytes_sent;
    int framed_bytes;     // bytes that were not simply ignored
    int frames_closed;
    int results_checked;

    // Idling switches and the receiver's long hold, set by the tests.
    logic tx_idle_on;
    logic rx_idle_on;
    int   rx_hold_cycles;

    function automatic void reset_decoder_model();
        frame_is_open = 1'b0;
        slot_index    = '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            slot_bytes[i] = 8'h00;
        end
        main_level   = 1'b1;
        status_level = 1'b1;
    endfunction

    // A slot holds ASCII; its digit is the byte less '0', wrapped to 16 bits.
    function automatic logic [acfd_pkg::CODE_W-1:0] slot_digit(input int slot);
        logic [acfd_pkg::CODE_W-1:0] raw;
        raw = acfd_pkg::CODE_W'(slot_bytes[slot]);
        return raw - acfd_pkg::CODE_W'(acfd_pkg::CH_ZERO);
    endfunction

    function automatic void store_at_index(input logic [7:0] b);
        if (slot_index < FRAME_SLOTS) begin
            slot_bytes[slot_index] = b;
        end
    endfunction

    // Advances the model by one received byte and returns the pin result.
    function automatic pin_result_t decode_byte(input logic [7:0] b);
        pin_result_t r;
        r = '0;
        if (b == acfd_pkg::CH_OPEN) begin
            frame_is_open = 1'b1;
            slot_index    = '0;
        end else if (b == acfd_pkg::CH_CLOSE) begin
            // A close is stored and decoded even when no frame was open.
            store_at_index(b);
            frame_is_open = 1'b0;
            slot_index    = '0;
            r.command_code = slot_digit(3) + slot_digit(2) * acfd_pkg::SCALE_10
                           + slot_digit(1) * acfd_pkg::SCALE_100;
            r.data_value   = slot_digit(8) + slot_digit(7) * acfd_pkg::SCALE_10
                           + slot_digit(6) * acfd_pkg::SCALE_100
                           + slot_digit(5) * acfd_pkg::SCALE_1000;
            r.frame_done   = 1'b1;
            frames_closed++;
            if (r.command_code == acfd_pkg::CMD_MAIN_OFF) begin
                main_level = 1'b0;
            end else if (r.command_code == acfd_pkg::CMD_MAIN_ON) begin
                main_level = 1'b1;
            end else if (r.command_code == acfd_pkg::CMD_STATUS) begin
                if (r.data_value != '0) begin
                    status_level = 1'b0;
                    main_level   = 1'b1;
                end else begin
                    status_level = 1'b1;
                end
            end
        end
        if (frame_is_open) begin
            store_at_index(b);
            slot_index = slot_index + 4'd1;
            if (slot_index >= FRAME_SLOTS) begin
                slot_index = '0;
            end
        end
        r.main_pin   = main_level;
        r.status_pin = status_level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge and returns at a falling edge, so
    // valid and the byte change only there and each gets one assignment
    // per step. The byte is modeled at the rising edge that accepts it.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (frame_is_open || b == acfd_pkg::CH_OPEN || b == acfd_pkg::CH_CLOSE) begin
            framed_bytes++;
        end
        expected_results.push_back(decode_byte(b));
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i]);
        end
    endtask

    // Any byte except the two delimiters.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b == acfd_pkg::CH_OPEN || b == acfd_pkg::CH_CLOSE);
        return b;
    endfunction

    // Sends a number as ASCII digits, most significant first. Now and then
    // a digit is replaced by an arbitrary byte to exercise non-digit slots.
    task automatic send_digits(input int number, input int count);
        int div;
        div = 1;
        for (int k = 1; k < count; k++) begin
            div *= 10;
        end
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_byte(body_byte());
            end else begin
                send_byte(acfd_pkg::CH_ZERO + 8'((number / div) % 10));
            end
            div /= 10;
        end
    endtask

    task automatic send_random_frame();
        int kind;
        int command;
        int value;
        int len;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            // Well formed: open, command, spacer slot, value, close.
            send_byte(acfd_pkg::CH_OPEN);
            case ($urandom_range(0, 4))
                0: command = 1;
                1: command = 2;
                2, 3: command = 4;
                default: command = $urandom_range(0, 999);
            endcase
            send_digits(command, acfd_pkg::CMD_DIGITS);
            send_byte(body_byte());
            value = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9999);
            send_digits(value, acfd_pkg::VAL_DIGITS);
            send_byte(acfd_pkg::CH_CLOSE);
        end else if (kind == 7) begin
            // Short frame: the decode sees leftovers from earlier frames.
            send_byte(acfd_pkg::CH_OPEN);
            len = $urandom_range(0, 7);
            for (int i = 0; i < len; i++) begin
                send_byte(acfd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            send_byte(acfd_pkg::CH_CLOSE);
        end else if (kind == 8) begin
            // Overlong frame: the write index wraps past the last slot.
            send_byte(acfd_pkg::CH_OPEN);
            len = $urandom_range(9, 20);
            for (int i = 0; i < len; i++) begin
                send_byte(body_byte());
            end
            send_byte(acfd_pkg::CH_CLOSE);
        end else begin
            // Noise, with stray delimiters mixed in.
            len = $urandom_range(1, 5);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 7))
                    0: send_byte(acfd_pkg::CH_OPEN);
                    1: send_byte(acfd_pkg::CH_CLOSE);
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // Lowers valid and waits until every expected result has been taken.
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && expected_results.size() != 0; i++) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Right after reset: a close with no open frame still decodes the
    // all-zero store, and the extreme byte values outside a frame are ignored.
    task automatic test_stray_bytes();
        send_byte(acfd_pkg::CH_CLOSE);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // One frame per command: status off with main on, main off, main on, and
    // status back on by a zero value. Short frames reuse the value slots.
    task automatic test_pin_commands();
        send_text("<004x0005>");
        send_text("<001>");
        send_text("<002>");
        send_text("<004y0000>");
    endtask

    task automatic test_random_frames();
        int target;
        target = framed_bytes + RANDOM_ITEMS;
        while (framed_bytes < target) begin
            send_random_frame();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering bytes, so the result queue fills and the input stalls.
    task automatic test_output_backpressure();
        logic saved_idle;
        saved_idle     = tx_idle_on;
        tx_idle_on     = 1'b0;
        rx_hold_cycles = 64;
        send_text("<001x0000>");
        send_text("<004x1234>");
        send_text("<002>");
        tx_idle_on = saved_idle;
    endtask

    // The sender pauses until every result is out, then resumes mid-stream.
    task automatic test_drain_pause();
        send_text("<004z");
        wait_results_drained();
        repeat (4) @(negedge aclk);
        send_text("0000>");
        send_random_frame();
    endtask

    // Last stretch: no idling on either side, one transaction per cycle.
    task automatic test_full_rate();
        int target;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        target = framed_bytes + FULL_RATE_ITEMS;
        while (framed_bytes < target) begin
            send_random_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver. Ready changes only at the falling edge. A requested long
    // hold is counted down here; otherwise ready drops in short bursts.
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int rx_gap;
        rx_gap  = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_gap > 0) begin
                m_ready <= 1'b0;
                rx_gap--;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                rx_gap = $urandom_range(0, 3);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every accepted result transaction is matched against the oldest
    // expectation; the run carries on after a mismatch.
    always @(posedge aclk) begin : result_checker
        pin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction arrived with no expectation waiting");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_main_pin !== want.main_pin) begin
                    $error("main_pin: expected %0d, actual %0d", want.main_pin, m_main_pin);
                    error_count++;
                end
                if (m_status_pin !== want.status_pin) begin
                    $error("status_pin: expected %0d, actual %0d",
                           want.status_pin, m_status_pin);
                    error_count++;
                end
                if (m_frame_done !== want.frame_done) begin
                    $error("frame_done: expected %0d, actual %0d",
                           want.frame_done, m_frame_done);
                    error_count++;
                end
                if (m_command_code !== want.command_code) begin
                    $error("command_code: expected %0d, actual %0d",
                           want.command_code, m_command_code);
                    error_count++;
                end
                if (m_data_value !== want.data_value) begin
                    $error("data_value: expected %0d, actual %0d",
                           want.data_value, m_data_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : cycle_watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("ascii_command_frame_decoder test failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_rx_byte       = 8'h00;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold_cycles  = 0;
        error_count     = 0;
        bytes_sent      = 0;
        framed_bytes    = 0;
        frames_closed   = 0;
        results_checked = 0;
        reset_decoder_model();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_stray_bytes();
        test_pin_commands();
        test_random_frames();
        test_output_backpressure();
        test_drain_pause();
        test_full_rate();

        // Let the pipeline empty, then keep the clock running so that a
        // spurious late result would still be caught.
        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end

        $display("Sent %0d bytes (%0d inside frames or on delimiters), closed %0d frames,",
                 bytes_sent, framed_bytes, frames_closed);
        $display("and compared %0d result transactions under idling and backpressure.",
                 results_checked);
        if (error_count == 0) begin
            $display("ascii_command_frame_decoder test passed");
        end else begin
            $display("ascii_command_frame_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/acfd_pkg.sv
hw/rtl/acfd_front.sv
hw/rtl/acfd_queue.sv
hw/rtl/acfd_back.sv
hw/rtl/ascii_command_frame_decoder.sv
tb/sv/testbench.sv
